// File: rtl/cfmp_pkg.sv
// Shared types, character codes, token phase codes and helper functions
// for the cron field mask parser. No dependencies.
package cfmp_pkg;

  localparam int MASK_W = 64;
  localparam int NUM_W  = 31;
  localparam int VAL_W  = 6;
  localparam int STP_W  = 7;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] SUB_START = 2'd0;
  localparam logic [1:0] SUB_SIGN  = 2'd1;
  localparam logic [1:0] SUB_DIG   = 2'd2;
  localparam logic [1:0] SUB_END   = 2'd3;

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_STEP   = 2'd2;

  localparam logic [3:0] PH_EMPTY = 4'd0;
  localparam logic [3:0] PH_STAR  = 4'd12;

  localparam logic [NUM_W-1:0] NUM_SEVEN = NUM_W'(7);
  localparam logic [STP_W-1:0] STP_SAT   = STP_W'(64);

  localparam logic [1:0] REG_MIN = 2'd0;
  localparam logic [1:0] REG_MAX = 2'd1;
  localparam logic [1:0] REG_SUN = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_data_t;

  typedef struct packed {
    logic [MASK_W-1:0] value_mask;
    logic              parse_ok;
  } out_data_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
    logic             seven_is_sunday;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic finish;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic go_finish;
    logic is_last;
    logic fin_go;
    logic exp_done;
  } sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_EXPAND,
    ST_EMIT
  } state_t;

  function automatic logic [NUM_W-1:0] map_seven(input logic [NUM_W-1:0] v,
                                                 input logic en);
    return (en && v == NUM_SEVEN) ? '0 : v;
  endfunction

  function automatic logic [VAL_W-1:0] clamp_value(input logic [NUM_W-1:0] v,
                                                   input logic [VAL_W-1:0] mn,
                                                   input logic [VAL_W-1:0] mx);
    logic [NUM_W-1:0] t;
    t = (v < NUM_W'(mn)) ? NUM_W'(mn) : v;
    return (t > NUM_W'(mx)) ? mx : t[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/cron_field_mask_parser.sv
// Cron field mask parser. A non-final character is taken while idle; a comma
// holds intake while its token's range is walked, n values (0..64).
// A final character finishes any open token when no error is latched, then its
// result is registered once the output is free. The range iterator visits one value per cycle. One field at a time.
// Synchronous active-low reset clears field state and loads min 0, max 59,
// weekday mapping off.
module cron_field_mask_parser
  import cfmp_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_data_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r;
  logic      out_free;
  cmd_t      cmd;
  sts_t      sts;
  out_data_t res;

  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MIN: cfg_nxt.min_value       = pwdata[VAL_W-1:0];
        REG_MAX: cfg_nxt.max_value       = pwdata[VAL_W-1:0];
        REG_SUN: cfg_nxt.seven_is_sunday = pwdata[0];
        default: cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN: prdata = 32'(cfg_r.min_value);
      REG_MAX: prdata = 32'(cfg_r.max_value);
      REG_SUN: prdata = 32'(cfg_r.seven_is_sunday);
      default: prdata = '0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value       <= '0;
      cfg_r.max_value       <= VAL_W'(59);
      cfg_r.seven_is_sunday <= 1'b0;
      out_valid_r           <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cfmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cfmp_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

endmodule

// File: rtl/cfmp_ctrl.sv
// Sequencer for the cron field mask parser: character intake, token finish,
// range expansion and result hand-off. Uses cfmp_pkg.
module cfmp_ctrl
  import cfmp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   out_free,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   in_stall
);

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.go_finish) begin
            state_nxt = ST_FINISH;
            last_nxt  = sts.is_last;
          end else if (sts.is_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_FINISH: begin
        if (sts.fin_go) begin
          state_nxt = ST_EXPAND;
        end else begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EXPAND: begin
        if (sts.exp_done) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_FINISH: cmd.finish = 1'b1;
      ST_EXPAND: cmd.step   = 1'b1;
      ST_EMIT:   cmd.emit   = out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

// File: rtl/cfmp_dp.sv
// Datapath for the cron field mask parser: token state, number accumulation,
// token finish evaluation, range iterator and mask register. Uses cfmp_pkg.
module cfmp_dp
  import cfmp_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_data_t  in_data,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_data_t res
);

  logic [3:0]            phase_r, phase_nxt;
  logic                  full_r, full_nxt;
  logic                  range_r, range_nxt;
  logic [NUM_W-1:0]      first_r, first_nxt;
  logic [NUM_W-1:0]      second_r, second_nxt;
  logic [NUM_W-1:0]      step_r, step_nxt;
  logic                  err_r, err_nxt;
  logic [VALUE_BITS-1:0] mask_r, mask_nxt;
  logic [STP_W-1:0]      v_r, v_nxt;
  logic [VAL_W-1:0]      hi_r, hi_nxt;
  logic [STP_W-1:0]      stp_r, stp_nxt;

  // character decode
  logic [7:0]       c;
  logic             ws, dig, handled;
  logic [3:0]       d;
  logic [1:0]       idx, sub;
  logic [NUM_W-1:0] slot;
  logic [NUM_W+3:0] prod;
  logic             ovf, chr_err, chr_fin;
  logic [3:0]       dec_phase;
  logic             dec_full, dec_range;
  logic [NUM_W-1:0] dec_first, dec_second, dec_step;

  // token finish
  logic [1:0]       fidx, fsub;
  logic             tok_err;
  logic [NUM_W-1:0] a_raw, b_raw, s_raw;
  logic [VAL_W-1:0] ca, cb, lo, hi;
  logic [STP_W-1:0] s_sat, v_sum;
  logic             ok;

  always_comb begin
    c    = in_data.char_code;
    ws   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    d    = 4'(c - CH_ZERO);
    idx  = phase_r[3:2];
    sub  = phase_r[1:0];
    case (idx)
      IDX_FIRST:  slot = first_r;
      IDX_SECOND: slot = second_r;
      default:    slot = step_r;
    endcase
    prod = (NUM_W+4)'({slot, 3'b000}) + (NUM_W+4)'({slot, 1'b0}) + (NUM_W+4)'(d);
    ovf  = prod[NUM_W+3:NUM_W] != '0;

    dec_phase  = phase_r;
    dec_full   = full_r;
    dec_range  = range_r;
    dec_first  = first_r;
    dec_second = second_r;
    dec_step   = step_r;
    chr_err    = 1'b0;
    chr_fin    = 1'b0;
    handled    = 1'b0;

    if (phase_r == PH_STAR) begin
      handled = 1'b1;
      if (!ws) begin
        if (c == CH_SLASH) begin
          dec_step  = '0;
          dec_phase = {IDX_STEP, SUB_START};
        end else if (c == CH_COMMA) begin
          chr_fin = 1'b1;
        end else begin
          chr_err = 1'b1;
        end
      end
    end else if (phase_r > PH_STAR) begin
      handled = 1'b1;
      chr_err = 1'b1;
    end else if (sub == SUB_START) begin
      if (ws) begin
        handled = 1'b1;
      end else if (c == CH_PLUS) begin
        handled   = 1'b1;
        dec_phase = {idx, SUB_SIGN};
      end else if (!dig) begin
        handled = 1'b1;
        if (idx == IDX_FIRST && c == CH_STAR) begin
          dec_full  = 1'b1;
          dec_phase = PH_STAR;
        end else if (idx == IDX_FIRST && c == CH_SLASH) begin
          dec_full  = 1'b1;
          dec_step  = '0;
          dec_phase = {IDX_STEP, SUB_START};
        end else if (idx == IDX_FIRST && c == CH_COMMA) begin
          chr_fin = 1'b1;
        end else begin
          chr_err = 1'b1;
        end
      end
    end

    if (!handled) begin
      if (dig) begin
        if (sub == SUB_END || ovf) begin
          chr_err = 1'b1;
        end else begin
          case (idx)
            IDX_FIRST:  dec_first  = prod[NUM_W-1:0];
            IDX_SECOND: dec_second = prod[NUM_W-1:0];
            default:    dec_step   = prod[NUM_W-1:0];
          endcase
          dec_phase = {idx, SUB_DIG};
        end
      end else if (sub == SUB_SIGN) begin
        chr_err = 1'b1;
      end else if (ws) begin
        dec_phase = {idx, SUB_END};
      end else if (c == CH_DASH && idx == IDX_FIRST) begin
        dec_range = 1'b1;
        dec_phase = {IDX_SECOND, SUB_START};
      end else if (c == CH_SLASH && idx < IDX_STEP) begin
        dec_step  = '0;
        dec_phase = {IDX_STEP, SUB_START};
      end else if (c == CH_COMMA) begin
        chr_fin = 1'b1;
      end else begin
        chr_err = 1'b1;
      end
    end
  end

  always_comb begin
    fidx = phase_r[3:2];
    fsub = phase_r[1:0];
    if (phase_r == PH_STAR || phase_r == PH_EMPTY) begin
      tok_err = 1'b0;
    end else if (phase_r > PH_STAR || fsub < SUB_DIG) begin
      tok_err = 1'b1;
    end else begin
      tok_err = (fidx == IDX_STEP) && (step_r == '0);
    end
    a_raw = full_r ? NUM_W'(cfg.min_value) : map_seven(first_r, cfg.seven_is_sunday);
    if (full_r) begin
      b_raw = NUM_W'(cfg.max_value);
    end else if (range_r) begin
      b_raw = map_seven(second_r, cfg.seven_is_sunday);
    end else begin
      b_raw = map_seven(first_r, cfg.seven_is_sunday);
    end
    s_raw = (fidx == IDX_STEP) ? step_r : NUM_W'(1);
    s_sat = (s_raw >= NUM_W'(STP_SAT)) ? STP_SAT : s_raw[STP_W-1:0];
    ca    = clamp_value(a_raw, cfg.min_value, cfg.max_value);
    cb    = clamp_value(b_raw, cfg.min_value, cfg.max_value);
    lo    = (ca < cb) ? ca : cb;
    hi    = (ca < cb) ? cb : ca;
    v_sum = v_r + stp_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    full_nxt   = full_r;
    range_nxt  = range_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    step_nxt   = step_r;
    err_nxt    = err_r;
    mask_nxt   = mask_r;
    v_nxt      = v_r;
    hi_nxt     = hi_r;
    stp_nxt    = stp_r;

    if (cmd.accept && !err_r) begin
      if (chr_err) begin
        err_nxt = 1'b1;
      end else if (!chr_fin) begin
        phase_nxt  = dec_phase;
        full_nxt   = dec_full;
        range_nxt  = dec_range;
        first_nxt  = dec_first;
        second_nxt = dec_second;
        step_nxt   = dec_step;
      end
    end

    if (cmd.finish || cmd.emit) begin
      phase_nxt  = PH_EMPTY;
      full_nxt   = 1'b0;
      range_nxt  = 1'b0;
      first_nxt  = '0;
      second_nxt = '0;
      step_nxt   = NUM_W'(1);
    end

    if (cmd.finish) begin
      err_nxt = err_r | tok_err;
      v_nxt   = STP_W'(lo);
      hi_nxt  = hi;
      stp_nxt = s_sat;
    end

    if (cmd.step) begin
      for (int i = 0; i < VALUE_BITS; i++) begin
        if (v_r == STP_W'(i)) begin
          mask_nxt[i] = 1'b1;
        end
      end
      v_nxt = v_sum;
    end

    if (cmd.emit) begin
      mask_nxt = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_EMPTY;
      full_r   <= 1'b0;
      range_r  <= 1'b0;
      first_r  <= '0;
      second_r <= '0;
      step_r   <= NUM_W'(1);
      err_r    <= 1'b0;
      mask_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      full_r   <= full_nxt;
      range_r  <= range_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      step_r   <= step_nxt;
      err_r    <= err_nxt;
      mask_r   <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    hi_r  <= hi_nxt;
    stp_r <= stp_nxt;
  end

  always_comb begin
    sts.go_finish = !err_r && !chr_err && (chr_fin || in_data.is_last);
    sts.is_last   = in_data.is_last;
    sts.fin_go    = !tok_err && (phase_r != PH_EMPTY);
    sts.exp_done  = v_sum > STP_W'(hi_r);
    ok             = !err_r && (mask_r != '0);
    res.value_mask = ok ? MASK_W'(mask_r) : '0;
    res.parse_ok   = ok;
  end

endmodule

// File: rtl/cfmp_checker.sv
// Port-level checks for the cron field mask parser, bound to the top level.
// Uses cfmp_pkg.
module cfmp_checker
  import cfmp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_data_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_data_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_ok_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.parse_ok == (out_data.value_mask != '0))
    else $error("parse_ok disagrees with mask");

  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared right after a request");

  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while intake was open");

endmodule

bind cron_field_mask_parser cfmp_checker u_cfmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/tb_cron_field_mask_parser.sv
// Self-checking testbench for cron_field_mask_parser: directed field table, then random
// cron fields under several register settings, scored by an in-bench field parser model.
// Depends on rtl/cfmp_pkg.sv and rtl/cron_field_mask_parser.sv.
module tb_cron_field_mask_parser
  import cfmp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYC    = 300;
  localparam int DRAIN_CYC   = 80;
  localparam int PHASE_ITEMS = 240;
  localparam int NUM_PHASES  = 8;
  localparam int DIR_N       = 25;
  localparam logic [7:0]  FLAG_FULL  = 8'h01;
  localparam logic [7:0]  FLAG_RANGE = 8'h02;
  localparam logic [31:0] NUM_MAX    = 32'h7FFF_FFFF;
  localparam logic [63:0] MASK_0_59  = 64'h0FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MASK_59    = 64'h0800_0000_0000_0000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_data_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_data_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cron_field_mask_parser #(.VALUE_BITS(64)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic [63:0] mask;
    logic        ok;
  } dir_row_t;

  dir_row_t dir_tab [0:DIR_N-1] = '{
    '{CH_STAR,  1'b1, 1'b1, MASK_0_59, 1'b1},
    '{"0",      1'b1, 1'b1, 64'h1,     1'b1},
    '{"5",      1'b0, 1'b0, 64'h0,     1'b0},
    '{"9",      1'b1, 1'b1, MASK_59,   1'b1},
    '{CH_DASH,  1'b1, 1'b1, 64'h0,     1'b0},
    '{CH_COMMA, 1'b1, 1'b1, 64'h0,     1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 64'h0,     1'b0},
    '{"0",      1'b1, 1'b1, 64'h0,     1'b0},
    '{CH_PLUS,  1'b0, 1'b0, 64'h0,     1'b0},
    '{"3",      1'b0, 1'b0, 64'h0,     1'b0},
    '{CH_DASH,  1'b0, 1'b0, 64'h0,     1'b0},
    '{"1",      1'b1, 1'b0, 64'h0,     1'b0},
    '{"5",      1'b0, 1'b0, 64'h0,     1'b0},
    '{CH_SPACE, 1'b0, 1'b0, 64'h0,     1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 64'h0,     1'b0},
    '{"2",      1'b1, 1'b0, 64'h0,     1'b0},
    '{CH_STAR,  1'b0, 1'b0, 64'h0,     1'b0},
    '{CH_SLASH, 1'b0, 1'b0, 64'h0,     1'b0},
    '{"7",      1'b1, 1'b0, 64'h0,     1'b0},
    '{"2",      1'b0, 1'b0, 64'h0,     1'b0},
    '{CH_SPACE, 1'b0, 1'b0, 64'h0,     1'b0},
    '{"3",      1'b1, 1'b1, 64'h0,     1'b0},
    '{8'hFF,    1'b1, 1'b1, 64'h0,     1'b0},
    '{CH_TAB,   1'b0, 1'b0, 64'h0,     1'b0},
    '{"4",      1'b1, 1'b0, 64'h0,     1'b0}
  };

  // parser model state and its copy of the registers
  logic [5:0]  cf_min;
  logic [5:0]  cf_max;
  logic        cf_sun;
  logic [63:0] pr_mask;
  logic [31:0] pr_first;
  logic [31:0] pr_second;
  logic [31:0] pr_step;
  logic [3:0]  pr_phase;
  logic [7:0]  pr_flags;
  logic        pr_err;

  out_data_t   expected_results[$];
  logic [7:0]  fld[$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;
  bit          hold_pending = 1'b0;

  function automatic void clear_token();
    pr_first  = '0;
    pr_second = '0;
    pr_step   = 32'd1;
    pr_phase  = PH_EMPTY;
    pr_flags  = '0;
  endfunction

  function automatic void clear_field();
    pr_mask = '0;
    pr_err  = 1'b0;
    clear_token();
  endfunction

  function automatic logic [31:0] sunday_map(input logic [31:0] v);
    return (cf_sun && v == 32'd7) ? 32'd0 : v;
  endfunction

  function automatic logic [5:0] clamp6(input logic [31:0] v);
    logic [31:0] t;
    t = (v < {26'd0, cf_min}) ? {26'd0, cf_min} : v;
    return (t > {26'd0, cf_max}) ? cf_max : t[5:0];
  endfunction

  function automatic void mark_value(input logic [31:0] v);
    pr_mask[clamp6(sunday_map(v))] = 1'b1;
  endfunction

  function automatic void mark_span(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] st);
    longint unsigned lo, hi, tmp, v, s;
    lo = clamp6(a);
    hi = clamp6(b);
    s  = (st == 0) ? 1 : st;
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    for (v = lo; v <= hi; v += s) pr_mask[v] = 1'b1;
  endfunction

  function automatic void end_token();
    logic [1:0] idx, sub;
    idx = pr_phase[3:2];
    sub = pr_phase[1:0];
    if (pr_phase == PH_STAR) begin
      mark_span({26'd0, cf_min}, {26'd0, cf_max}, 32'd1);
    end else if (pr_phase == PH_EMPTY) begin
    end else if (pr_phase > PH_STAR || sub < SUB_DIG) begin
      pr_err = 1'b1;
    end else if (idx == IDX_FIRST) begin
      mark_value(pr_first);
    end else if (idx == IDX_SECOND) begin
      mark_span(sunday_map(pr_first), sunday_map(pr_second), 32'd1);
    end else if (pr_step == 0) begin
      pr_err = 1'b1;
    end else if ((pr_flags & FLAG_FULL) != 0) begin
      mark_span({26'd0, cf_min}, {26'd0, cf_max}, pr_step);
    end else if ((pr_flags & FLAG_RANGE) != 0) begin
      mark_span(sunday_map(pr_first), sunday_map(pr_second), pr_step);
    end else begin
      mark_value(pr_first);
    end
    clear_token();
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic ws, dig;
    logic [1:0] idx, sub;
    logic [31:0] d, cur;
    ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    idx = pr_phase[3:2];
    sub = pr_phase[1:0];
    d   = {24'd0, c - CH_ZERO};
    cur = (idx == IDX_FIRST) ? pr_first : ((idx == IDX_SECOND) ? pr_second : pr_step);
    if (pr_phase == PH_STAR) begin
      if (ws) begin
      end else if (c == CH_SLASH) begin
        pr_step  = '0;
        pr_phase = {IDX_STEP, SUB_START};
      end else if (c == CH_COMMA) begin
        end_token();
      end else begin
        pr_err = 1'b1;
      end
    end else if (pr_phase > PH_STAR) begin
      pr_err = 1'b1;
    end else if (sub == SUB_START && !dig) begin
      if (ws) begin
      end else if (c == CH_PLUS) begin
        pr_phase = {idx, SUB_SIGN};
      end else if (idx == IDX_FIRST && c == CH_STAR) begin
        pr_flags = pr_flags | FLAG_FULL;
        pr_phase = PH_STAR;
      end else if (idx == IDX_FIRST && c == CH_SLASH) begin
        pr_flags = pr_flags | FLAG_FULL;
        pr_step  = '0;
        pr_phase = {IDX_STEP, SUB_START};
      end else if (idx == IDX_FIRST && c == CH_COMMA) begin
        end_token();
      end else begin
        pr_err = 1'b1;
      end
    end else if (dig) begin
      if (sub == SUB_END || cur > (NUM_MAX - d) / 10) begin
        pr_err = 1'b1;
      end else begin
        cur = cur * 10 + d;
        case (idx)
          IDX_FIRST:  pr_first  = cur;
          IDX_SECOND: pr_second = cur;
          default:    pr_step   = cur;
        endcase
        pr_phase = {idx, SUB_DIG};
      end
    end else if (sub == SUB_SIGN) begin
      pr_err = 1'b1;
    end else if (ws) begin
      pr_phase = {idx, SUB_END};
    end else if (c == CH_DASH && idx == IDX_FIRST) begin
      pr_flags = pr_flags | FLAG_RANGE;
      pr_phase = {IDX_SECOND, SUB_START};
    end else if (c == CH_SLASH && idx < IDX_STEP) begin
      pr_step  = '0;
      pr_phase = {IDX_STEP, SUB_START};
    end else if (c == CH_COMMA) begin
      end_token();
    end else begin
      pr_err = 1'b1;
    end
  endfunction

  // returns 1 when the character closes the field and yields a result
  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output out_data_t r);
    logic good;
    r = '0;
    if (!pr_err) take_char(c);
    if (!last) return 1'b0;
    if (!pr_err) end_token();
    good = !pr_err && (pr_mask != 0);
    r.value_mask = good ? pr_mask : '0;
    r.parse_ok   = good;
    clear_field();
    return 1'b1;
  endfunction

  // random field text
  function automatic void add_char(input logic [7:0] ch);
    fld.insert(fld.size(), ch);
  endfunction

  function automatic logic [7:0] ws_char();
    logic [7:0] r;
    r = 8'($urandom_range(9, 14));
    return (r > CH_CR) ? CH_SPACE : r;
  endfunction

  function automatic logic [7:0] gram_char();
    case ($urandom_range(0, 6))
      0:       return CH_PLUS;
      1:       return CH_DASH;
      2:       return CH_SLASH;
      3:       return CH_COMMA;
      4:       return CH_STAR;
      5:       return ws_char();
      default: return CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void pad();
    if ($urandom_range(0, 3) == 0) add_char(ws_char());
  endfunction

  function automatic longint unsigned pick_num();
    case ($urandom_range(0, 15))
      0:       return 64'd2147483647;
      1:       return 64'd2147483648;
      2:       return {$urandom, $urandom};
      3:       return 64'($urandom);
      4:       return 64'd7;
      5:       return 64'd0;
      default: return 64'($urandom_range(0, 70));
    endcase
  endfunction

  function automatic void put_num(input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) add_char(CH_PLUS);
    if ($urandom_range(0, 7) == 0) add_char(CH_ZERO);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void put_token();
    int kind;
    bit stepped;
    kind = $urandom_range(0, 7);
    pad();
    case (kind)
      0, 1:    add_char(CH_STAR);
      2, 3, 4: put_num(pick_num());
      5, 6: begin
        put_num(pick_num());
        pad();
        add_char(CH_DASH);
        pad();
        put_num(pick_num());
      end
      default: ;
    endcase
    stepped = (kind == 7) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 2) == 0);
    if (stepped) begin
      pad();
      add_char(CH_SLASH);
      pad();
      case ($urandom_range(0, 9))
        0:       put_num(64'd0);
        1:       put_num(pick_num());
        default: put_num(64'($urandom_range(1, 20)));
      endcase
    end
    pad();
  endfunction

  function automatic void build_field();
    int mode, n, pos;
    fld.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) add_char(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i != 0) add_char(CH_COMMA);
        put_token();
      end
      if (fld.size() == 0) add_char(CH_SPACE);
      pos = $urandom_range(0, fld.size() - 1);
      if (mode == 1) begin
        fld[pos] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) : gram_char();
      end else if (mode == 2) begin
        fld.insert(pos, gram_char());
      end
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input logic [63:0] tmask, input logic tok);
    int gap;
    out_data_t r;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: ch, is_last: last};
    do @(posedge clk); while (in_stall);
    if (parse_char(ch, last, r)) begin
      if (typed) begin
        r.value_mask = tmask;
        r.parse_ok   = tok;
      end
      expected_results.insert(expected_results.size(), r);
    end
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (reg_idx)
      REG_MIN: cf_min = val[5:0];
      REG_MAX: cf_max = val[5:0];
      default: cf_sun = val[0];
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // result side
  initial begin
    int gap;
    out_data_t want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_pending = 1'b0;
        out_stall <= 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          do @(posedge clk); while (!out_valid);
          repeat (gap) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!out_valid);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mask=%h ok=%b", out_data.value_mask, out_data.parse_ok);
      end else begin
        want = expected_results.pop_front();
        if (out_data.value_mask !== want.value_mask || out_data.parse_ok !== want.parse_ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: mask exp=%h act=%h, ok exp=%b act=%b",
                     want.value_mask, out_data.value_mask, want.parse_ok, out_data.parse_ok);
        end
      end
    end
  end

  // request side and register phases
  initial begin
    int sent;
    logic [5:0] mn, mx;
    logic sun;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cf_min   = 6'd0;
    cf_max   = 6'd59;
    cf_sun   = 1'b0;
    clear_field();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].mask,
                dir_tab[i].ok);

    for (int p = 1; p <= NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        1:       begin mn = 6'd0;  mx = 6'd59; sun = 1'b0; end
        2:       begin mn = 6'd0;  mx = 6'd63; sun = 1'b1; end
        3:       begin mn = 6'd0;  mx = 6'd7;  sun = 1'b1; end
        4:       begin mn = 6'd63; mx = 6'd0;  sun = 1'b0; end
        5:       begin mn = 6'd5;  mx = 6'd5;  sun = 1'b0; end
        6:       begin mn = 6'd1;  mx = 6'd12; sun = 1'b0; end
        7:       begin mn = 6'($urandom_range(0, 63)); mx = 6'($urandom_range(0, 63));
                       sun = 1'($urandom_range(0, 1)); end
        default: begin mn = 6'd63; mx = 6'd63; sun = 1'b1; end
      endcase
      cfg_write(REG_MIN, {26'd0, mn});
      cfg_write(REG_MAX, {26'd0, mx});
      cfg_write(REG_SUN, {31'd0, sun});
      no_idle = (p == 5);
      if (p == 3) hold_pending = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_field();
        for (int i = 0; i < fld.size(); i++)
          send_char(fld[i], i == fld.size() - 1, 1'b0, 64'h0, 1'b0);
        sent += fld.size();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("[cron_field_mask_parser] OK");
    end else begin
      $display("[cron_field_mask_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[cron_field_mask_parser] ERROR");
    $finish;
  end

endmodule

// File: cron_field_mask_parser.f
rtl/cfmp_pkg.sv
rtl/cfmp_ctrl.sv
rtl/cfmp_dp.sv
rtl/cron_field_mask_parser.sv
rtl/cfmp_checker.sv
test/tb_cron_field_mask_parser.sv
